@@ hdl/shsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Half-step stepper driver package
// Shared constants for the stepper speed driver: command bytes, direction
// codes, step period scaling and the half-step coil pattern table.
// ----------------------------------------------------------------------------
package shsd_pkg;

    // Command bytes (ASCII).
    localparam logic [7:0] CMD_INC   = 8'h69;  // 'i'
    localparam logic [7:0] CMD_DEC   = 8'h64;  // 'd'
    localparam logic [7:0] CMD_STOP  = 8'h73;  // 's'
    localparam logic [7:0] CMD_DIG_0 = 8'h30;  // '0'
    localparam logic [7:0] CMD_DIG_5 = 8'h35;  // '5'
    localparam logic [7:0] CMD_DIG_9 = 8'h39;  // '9'

    // Request kinds carried in tuser.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CMD  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_MAX_SPEED  = 1'b0;
    localparam logic CFG_SPEED_STEP = 1'b1;

    // Step direction codes.
    localparam logic [1:0] DIR_HOLD = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_REV  = 2'd2;

    // Step period scaling, in microseconds.
    localparam logic [8:0]  PERIOD_PER_MAX   = 9'd300;
    localparam logic [7:0]  PERIOD_PER_SPEED = 8'd200;
    localparam logic [14:0] PERIOD_FLOOR     = 15'd1000;
    localparam logic [14:0] PERIOD_CEIL      = 15'd32767;

    // Reset values of the configuration registers.
    localparam logic [6:0] MAX_SPEED_RST  = 7'd10;
    localparam logic [6:0] SPEED_STEP_RST = 7'd1;

    // Preset speed for the digit '0'.
    localparam logic [9:0] SPEED_DIG_0 = 10'd10;

    typedef logic [6:0]  t_cfg;
    typedef logic [7:0]  t_speed;
    typedef logic [14:0] t_period;
    typedef logic [3:0]  t_coils;

    // Eight-phase half-step coil patterns: orange, yellow, pink, blue.
    function automatic t_coils phase_pattern(input logic [2:0] idx);
        t_coils pat;
        case (idx)
            3'd0:    pat = 4'h9;
            3'd1:    pat = 4'h8;
            3'd2:    pat = 4'hC;
            3'd3:    pat = 4'h4;
            3'd4:    pat = 4'h6;
            3'd5:    pat = 4'h2;
            3'd6:    pat = 4'h3;
            default: pat = 4'h1;
        endcase
        return pat;
    endfunction

endpackage

@@ hdl/stepper_half_step_speed_driver.sv @@
// ----------------------------------------------------------------------------
// Half-step stepper motor speed driver
// Drives four coils through the eight-phase half-step sequence from a stream
// of microsecond ticks and command bytes, one result word per input word.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Contents
// s_axis    in   tvalid/tready          tdata: cmd_char[7:0]; tuser: req_type
// m_axis    out  tvalid/tready          tdata: coils, speed_now, step_period_us
//                                       tuser: stepped
// cfg       in   i_cfg_we (no wait)     i_cfg_idx 0 max_speed, 1 speed_step
//
// Each word is decoded and applied to the state in the same cycle it is
// accepted, and its result lands in the output register at that edge. A new
// word can be accepted every cycle while the output register is empty or
// is being drained in the same cycle; when the sink stalls, the input side
// stalls with it. The longest path runs through the speed update, the
// saturation compare and the period multiply.
// Reset is synchronous and active low; it clears the phase, speed, countdown
// and coils, loads the register defaults and empties the output register.
// ----------------------------------------------------------------------------
module stepper_half_step_speed_driver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [6:0]  i_cfg_data,
    // Input words.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] cmd_char
    input  logic        s_axis_tuser,   // [0] req_type
    // Result words.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [3:0] coils, [11:4] speed_now,
                                        // [26:12] step_period_us, rest zero
    output logic        m_axis_tuser    // [0] stepped
);
    import shsd_pkg::*;

    // Configuration registers.
    t_cfg    r_max_speed, n_max_speed;
    t_cfg    r_speed_step, n_speed_step;

    // Motor state.
    logic [2:0] r_phase, n_phase;
    t_speed     r_speed, n_speed;
    logic [1:0] r_dir, n_dir;
    t_period    r_count, n_count;
    t_coils     r_coils, n_coils;

    // Output register.
    logic       r_out_valid, n_out_valid;
    t_coils     r_out_coils;
    logic       r_out_stepped;
    t_speed     r_out_speed;
    t_period    r_out_period;

    logic       w_accept;
    logic       w_stepped;
    logic       w_set;
    logic [9:0] w_cand;
    logic [9:0] w_lim;
    logic [9:0] w_dig;
    logic [3:0] w_num;
    t_period    w_period_now;
    t_period    w_period_next;

    // Period at the present speed feeds the countdown reload; the period at
    // the updated speed goes out with the result.
    shsd_period u_period_now (
        .i_max_speed (r_max_speed),
        .i_speed     (r_speed),
        .o_period    (w_period_now)
    );

    shsd_period u_period_next (
        .i_max_speed (r_max_speed),
        .i_speed     (n_speed),
        .o_period    (w_period_next)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // Configuration writes.
    always_comb begin
        n_max_speed  = r_max_speed;
        n_speed_step = r_speed_step;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_SPEED:  n_max_speed  = i_cfg_data;
                CFG_SPEED_STEP: n_speed_step = i_cfg_data;
                default:        n_max_speed  = r_max_speed;
            endcase
        end
    end

    // Command decode, speed saturation and tick handling.
    always_comb begin
        n_phase   = r_phase;
        n_speed   = r_speed;
        n_dir     = r_dir;
        n_count   = r_count;
        n_coils   = r_coils;
        w_stepped = 1'b0;
        w_set     = 1'b0;
        w_cand    = 10'd0;
        w_lim     = {3'b000, r_max_speed};
        w_num     = s_axis_tdata[3:0];
        // Digits '1'..'5' map to (n-6)*2, '6'..'9' to (n-5)*2.
        if (w_num <= 4'd5) begin
            w_dig = {6'd0, w_num} - 10'd6;
        end else begin
            w_dig = {6'd0, w_num} - 10'd5;
        end

        if (w_accept) begin
            if (s_axis_tuser == REQ_CMD) begin
                if (s_axis_tdata == CMD_INC) begin
                    w_set  = 1'b1;
                    w_cand = {{2{r_speed[7]}}, r_speed} + {3'b000, r_speed_step};
                end else if (s_axis_tdata == CMD_DEC) begin
                    w_set  = 1'b1;
                    w_cand = {{2{r_speed[7]}}, r_speed} - {3'b000, r_speed_step};
                end else if (s_axis_tdata == CMD_STOP) begin
                    w_set  = 1'b1;
                    w_cand = 10'd0;
                end else if (s_axis_tdata == CMD_DIG_0) begin
                    w_set  = 1'b1;
                    w_cand = SPEED_DIG_0;
                end else if (s_axis_tdata inside {[CMD_DIG_0 : CMD_DIG_9]}) begin
                    w_set  = 1'b1;
                    w_cand = {w_dig[8:0], 1'b0};
                end

                if (w_set) begin
                    if ($signed(w_cand) > $signed(w_lim)) begin
                        w_cand = w_lim;
                    end else if ($signed(w_cand) < -$signed(w_lim)) begin
                        w_cand = 10'd0 - w_lim;
                    end
                    n_speed = w_cand[7:0];
                    if ($signed(w_cand) > 0) begin
                        n_dir = DIR_FWD;
                    end else if ($signed(w_cand) < 0) begin
                        n_dir = DIR_REV;
                    end else begin
                        n_dir = DIR_HOLD;
                    end
                end
            end else begin
                // A tick: step when the countdown has run out, else count down.
                if (r_count == '0) begin
                    n_coils   = phase_pattern(r_phase);
                    w_stepped = 1'b1;
                    n_count   = w_period_now - 15'd1;
                    case (r_dir)
                        DIR_FWD: n_phase = r_phase + 3'd1;
                        DIR_REV: n_phase = r_phase - 3'd1;
                        default: n_phase = r_phase;
                    endcase
                end else begin
                    n_count = r_count - 15'd1;
                end
            end
        end
    end

    // The output register fills on accept and empties when the sink takes it.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed  <= MAX_SPEED_RST;
            r_speed_step <= SPEED_STEP_RST;
            r_phase      <= '0;
            r_speed      <= '0;
            r_dir        <= DIR_HOLD;
            r_count      <= '0;
            r_coils      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_max_speed  <= n_max_speed;
            r_speed_step <= n_speed_step;
            r_phase      <= n_phase;
            r_speed      <= n_speed;
            r_dir        <= n_dir;
            r_count      <= n_count;
            r_coils      <= n_coils;
            r_out_valid  <= n_out_valid;
        end
    end

    // Result payload carries no reset; it is qualified by r_out_valid.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_coils   <= n_coils;
            r_out_stepped <= w_stepped;
            r_out_speed   <= n_speed;
            r_out_period  <= w_period_next;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_period, r_out_speed, r_out_coils};
    assign m_axis_tuser  = r_out_stepped;

endmodule

@@ hdl/shsd_period.sv @@
// ----------------------------------------------------------------------------
// Step period calculator
// Computes 300*max_speed - 200*|speed| microseconds, held between 1000 and
// 32767.
// ----------------------------------------------------------------------------
module shsd_period (
    input  shsd_pkg::t_cfg    i_max_speed,
    input  shsd_pkg::t_speed  i_speed,
    output shsd_pkg::t_period o_period
);
    import shsd_pkg::*;

    logic [7:0]         w_mag;
    logic [15:0]        w_base;
    logic [15:0]        w_sub;
    logic signed [16:0] w_diff;

    always_comb begin
        w_mag  = i_speed[7] ? (8'd0 - i_speed) : i_speed;
        w_base = 16'(i_max_speed) * 16'(PERIOD_PER_MAX);
        w_sub  = 16'(w_mag) * 16'(PERIOD_PER_SPEED);
        w_diff = $signed({1'b0, w_base}) - $signed({1'b0, w_sub});
        if (w_diff < $signed({2'b00, PERIOD_FLOOR})) begin
            o_period = PERIOD_FLOOR;
        end else if (w_diff > $signed({2'b00, PERIOD_CEIL})) begin
            o_period = PERIOD_CEIL;
        end else begin
            o_period = w_diff[14:0];
        end
    end

endmodule
